// ===== src/cfdu_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdu_pkg
// Types and constants shared by the frame deframer's front, queue and back.
// ----------------------------------------------------------------------------
package cfdu_pkg;

   // Frame geometry: command, value, four epoch bytes, two tick bytes, checksum.
   localparam int FRAME_BYTES = 9;
   // Bytes kept between beats; the ninth byte is the one arriving.
   localparam int HIST_BYTES  = FRAME_BYTES - 1;
   localparam int FILL_W      = 4;
   localparam int SLOTS_W     = 9;

   // Reset value of the request slot register.
   localparam logic [SLOTS_W-1:0] SLOTS_RESET = 9'd256;

   // Command codes recognised by the classifier.
   localparam logic [7:0] CMD_ADC   = 8'h48;
   localparam logic [7:0] CMD_CLOCK = 8'h50;

   // Message kinds reported on the result channel.
   localparam logic [1:0] KIND_ADC     = 2'd0;
   localparam logic [1:0] KIND_CLOCK   = 2'd1;
   localparam logic [1:0] KIND_BAD_ID  = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // One decoded frame as it travels from the front to the back.
   typedef struct packed {
      logic [1:0]  msg_kind;
      logic [7:0]  cmd_code;
      logic [7:0]  payload_value;
      logic [31:0] epoch_count;
      logic [15:0] tick_count;
   } frame_type;

   // Fill state of the frame queue as seen by its neighbours.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/cfdu_front.sv =====
// ----------------------------------------------------------------------------
// cfdu_front
// Byte window, checksum test and command classification. One byte per beat.
// ----------------------------------------------------------------------------
module cfdu_front
   import cfdu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SLOTS_W-1:0]    csr_request_slots,
   input  queue_status_type      queue_status,
   output logic                  frame_push,
   output frame_type             frame_data
);

   logic [7:0]         hist_ff [HIST_BYTES];
   logic [7:0]         hist_in [HIST_BYTES];
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [SLOTS_W-1:0] slots_ff;
   logic [SLOTS_W-1:0] slots_in;
   logic               accept;
   logic               window_full;
   logic [7:0]         sum;
   logic               match;

   // A byte is taken whenever the queue has room.
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;
   assign csr_ready = 1'b1;

   // The window is complete once eight bytes are held and the ninth arrives.
   assign window_full = (fill_ff == FILL_W'(HIST_BYTES));

   // Checksum over bytes 1 to 7, modulo 256.
   always_comb begin
      sum = 8'd0;
      for (int i = 1; i < HIST_BYTES; i++) begin
         sum = sum + hist_ff[i];
      end
   end

   assign match      = window_full && (sum == req_rx_byte);
   assign frame_push = accept && match;

   // Field extraction and command classification.
   always_comb begin
      frame_data.cmd_code      = hist_ff[0];
      frame_data.payload_value = hist_ff[1];
      frame_data.epoch_count   = {hist_ff[5], hist_ff[4], hist_ff[3], hist_ff[2]};
      frame_data.tick_count    = {hist_ff[7], hist_ff[6]};
      unique case (hist_ff[0])
         CMD_ADC: begin
            frame_data.msg_kind = KIND_ADC;
         end
         CMD_CLOCK: begin
            if ({1'b0, hist_ff[1]} >= slots_ff) begin
               frame_data.msg_kind = KIND_BAD_ID;
            end else begin
               frame_data.msg_kind = KIND_CLOCK;
            end
         end
         default: begin
            frame_data.msg_kind = KIND_UNKNOWN;
         end
      endcase
   end

   // Next window: the history shifts on every accepted beat. On a mismatch the
   // oldest byte falls out and eight stay; on a match the window empties.
   always_comb begin
      for (int i = 0; i < HIST_BYTES - 1; i++) begin
         hist_in[i] = accept ? hist_ff[i+1] : hist_ff[i];
      end
      hist_in[HIST_BYTES-1] = accept ? req_rx_byte : hist_ff[HIST_BYTES-1];

      fill_in = fill_ff;
      if (accept) begin
         if (window_full) begin
            fill_in = match ? '0 : fill_ff;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end

      slots_in = (csr_valid && csr_ready) ? csr_request_slots : slots_ff;
   end

   // Control state and the slot register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         slots_ff <= SLOTS_RESET;
      end else begin
         fill_ff  <= fill_in;
         slots_ff <= slots_in;
      end
   end

   // Window bytes need no reset: only the held count is ever read.
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   // A frame is only ever produced from a full window.
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      frame_push |-> window_full && !queue_status.full)
      else $error("frame pushed without a full window or with the queue full");

   // A completed frame empties the window.
   a_empty_after_frame: assert property (@(posedge clock) disable iff (reset)
      frame_push |=> fill_ff == '0)
      else $error("window not emptied after a frame");

   // The held count never passes eight.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(HIST_BYTES))
      else $error("window count out of range");

endmodule

// ===== src/cfdu_queue.sv =====
// ----------------------------------------------------------------------------
// cfdu_queue
// Short frame queue that decouples the byte front from the result back.
// ----------------------------------------------------------------------------
module cfdu_queue
   import cfdu_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_data,
   input  logic             pop,
   output frame_type        pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written on push; entries are only read once filled.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // Neither overflow nor underflow.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full) && !(pop && status.empty))
      else $error("frame queue overflow or underflow");

   // Occupancy grows by one on a lone push.
   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("frame queue count did not follow a push");

endmodule

// ===== src/cfdu_back.sv =====
// ----------------------------------------------------------------------------
// cfdu_back
// Result output register, refilled from the frame queue.
// ----------------------------------------------------------------------------
module cfdu_back
   import cfdu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  frame_type        queue_data,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_msg_kind,
   output logic [7:0]       rsp_cmd_code,
   output logic [7:0]       rsp_payload_value,
   output logic [31:0]      rsp_epoch_count,
   output logic [15:0]      rsp_tick_count
);

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   frame_type rsp_data_ff;
   logic      load;

   // The register takes a new frame when it is empty or its beat is taken.
   assign load         = !rsp_valid_ff || !rsp_stall;
   assign queue_pop    = load && !queue_status.empty;
   assign rsp_valid_in = load ? !queue_status.empty : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rsp_data_ff <= queue_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_msg_kind      = rsp_data_ff.msg_kind;
   assign rsp_cmd_code      = rsp_data_ff.cmd_code;
   assign rsp_payload_value = rsp_data_ff.payload_value;
   assign rsp_epoch_count   = rsp_data_ff.epoch_count;
   assign rsp_tick_count    = rsp_data_ff.tick_count;

endmodule

// ===== src/checksummed_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_unit
// Finds checksummed nine-byte frames in a serial byte stream and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received byte per beat (req_valid / req_stall).
//   rsp_*  : one decoded frame per beat (rsp_valid / rsp_stall): kind,
//            command, value, little-endian epoch and ticks.
//   csr_*  : write of the request slot count; csr_ready is always high.
//            Write it only while no frame is in flight.
//   A byte is taken every cycle while the frame queue has room. The frame
//   completed by a byte is found by the front combinationally, pushed into
//   the frame queue as that byte is taken and then loaded into the back's
//   output register, which drives rsp. Throughput is one byte per cycle
//   while the queue has room; a frame needs nine bytes. When rsp_stall is
//   held, frames collect in a queue of QUEUE_DEPTH entries plus the output
//   register; once the queue is full req_stall rises.
//   Reset empties the window and the queue and sets the slot count to 256.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_unit
   import cfdu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLOTS_W-1:0] csr_request_slots,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_msg_kind,
   output logic [7:0]         rsp_cmd_code,
   output logic [7:0]         rsp_payload_value,
   output logic [31:0]        rsp_epoch_count,
   output logic [15:0]        rsp_tick_count
);

   queue_status_type queue_status;
   logic             frame_push;
   frame_type        frame_data;
   logic             queue_pop;
   frame_type        queue_data;

   // Byte window, checksum and classification.
   cfdu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_request_slots (csr_request_slots),
      .queue_status      (queue_status),
      .frame_push        (frame_push),
      .frame_data        (frame_data)
   );

   // Decoupling queue.
   cfdu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   // Result output register.
   cfdu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_status      (queue_status),
      .queue_data        (queue_data),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_msg_kind      (rsp_msg_kind),
      .rsp_cmd_code      (rsp_cmd_code),
      .rsp_payload_value (rsp_payload_value),
      .rsp_epoch_count   (rsp_epoch_count),
      .rsp_tick_count    (rsp_tick_count)
   );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checksummed frame deframer unit.
// A byte-level predictor keeps its own nine-byte window, fill count and slot
// limit. It works out which received bytes complete a frame and what that
// frame decodes to. Each result beat is compared field by field with the
// oldest predicted frame. The stimulus starts with a few hand-built frames
// and slot-limit corner cases. Random traffic follows: mostly well-formed
// frames with random content, mixed with corrupted checksums, cut-off frames
// and loose noise bytes, under bursty sending and several stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import cfdu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte       = 8'h00;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [SLOTS_W-1:0] csr_request_slots = '0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic [1:0]         rsp_msg_kind;
   logic [7:0]         rsp_cmd_code;
   logic [7:0]         rsp_payload_value;
   logic [31:0]        rsp_epoch_count;
   logic [15:0]        rsp_tick_count;

   // Predictor state: the received-byte window, its fill and the slot limit.
   logic [7:0]         frame_window [FRAME_BYTES];
   int                 window_fill;
   logic [SLOTS_W-1:0] slot_limit;
   frame_type          pending_frames [$];

   // Sender and receiver pacing.
   bit                 gaps_on     = 1'b0;
   int                 burst_left  = 0;
   stall_mode_type     stall_mode  = STALL_NONE;
   int                 stall_left  = 0;

   // Tallies for the summary.
   int                 errors         = 0;
   int                 bytes_sent     = 0;
   int                 frames_checked = 0;
   int                 kind_seen [4]  = '{0, 0, 0, 0};

   always #4 clock = ~clock;

   checksummed_frame_deframer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_request_slots (csr_request_slots),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_msg_kind      (rsp_msg_kind),
      .rsp_cmd_code      (rsp_cmd_code),
      .rsp_payload_value (rsp_payload_value),
      .rsp_epoch_count   (rsp_epoch_count),
      .rsp_tick_count    (rsp_tick_count)
   );

   // Pushes one received byte into the window; returns 1 and the decoded
   // frame when the window holds nine bytes whose checksum agrees.
   function automatic bit predict_frame(input logic [7:0] rx, output frame_type frame);
      logic [7:0] sum;
      int         k;
      frame = '0;
      if (window_fill >= FRAME_BYTES) window_fill = HIST_BYTES;
      frame_window[window_fill] = rx;
      window_fill++;
      if (window_fill < FRAME_BYTES) return 1'b0;
      sum = 8'h00;
      for (k = 1; k <= 7; k++) sum += frame_window[k];
      // A bad checksum drops the oldest byte and the window slides on.
      if (sum != frame_window[8]) begin
         for (k = 0; k < HIST_BYTES; k++) frame_window[k] = frame_window[k + 1];
         window_fill = HIST_BYTES;
         return 1'b0;
      end
      frame.cmd_code      = frame_window[0];
      frame.payload_value = frame_window[1];
      frame.epoch_count   = {frame_window[5], frame_window[4], frame_window[3],
                             frame_window[2]};
      frame.tick_count    = {frame_window[7], frame_window[6]};
      if (frame.cmd_code == CMD_ADC) begin
         frame.msg_kind = KIND_ADC;
      end else if (frame.cmd_code == CMD_CLOCK) begin
         frame.msg_kind = ({1'b0, frame.payload_value} >= slot_limit) ? KIND_BAD_ID
                                                                       : KIND_CLOCK;
      end else begin
         frame.msg_kind = KIND_UNKNOWN;
      end
      window_fill = 0;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Follows every accepted beat on all three channels at the rising edge.
   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      if (reset) begin
         window_fill = 0;
         slot_limit  = SLOTS_RESET;
      end else begin
         if (csr_valid && csr_ready) slot_limit = csr_request_slots;
         if (req_valid && !req_stall) begin
            if (predict_frame(req_rx_byte, want)) pending_frames.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_msg_kind, rsp_cmd_code, rsp_payload_value, rsp_epoch_count,
                   rsp_tick_count};
            if (pending_frames.size() == 0) begin
               $display("%0t: unexpected frame, expected none, actual kind %0d cmd 0x%0h",
                        $time, got.msg_kind, got.cmd_code);
               errors++;
            end else begin
               want = pending_frames.pop_front();
               check_field("msg_kind", want.msg_kind, got.msg_kind);
               check_field("cmd_code", want.cmd_code, got.cmd_code);
               check_field("payload_value", want.payload_value, got.payload_value);
               check_field("epoch_count", want.epoch_count, got.epoch_count);
               check_field("tick_count", want.tick_count, got.tick_count);
               frames_checked++;
               kind_seen[got.msg_kind]++;
            end
         end
      end
   end

   // Receiver stalls: none, short occasional ones, or long frequent ones.
   always @(posedge clock) begin
      if (reset || stall_mode == STALL_NONE) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_mode == STALL_HEAVY && $urandom_range(0, 1) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(3, 19);
      end else if (stall_mode == STALL_LIGHT && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Sends one byte beat; with gaps on, bursts of random length are
   // separated by random idle cycles.
   task automatic send_rx_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends the first n_bytes of a frame, optionally with a broken checksum.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] value,
                             input logic [31:0] epoch, input logic [15:0] ticks,
                             input bit corrupt, input int n_bytes);
      logic [7:0] octets [FRAME_BYTES];
      logic [7:0] sum;
      int         k;
      octets[0] = cmd;
      octets[1] = value;
      octets[2] = epoch[7:0];
      octets[3] = epoch[15:8];
      octets[4] = epoch[23:16];
      octets[5] = epoch[31:24];
      octets[6] = ticks[7:0];
      octets[7] = ticks[15:8];
      sum = 8'h00;
      for (k = 1; k <= 7; k++) sum += octets[k];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      octets[8] = sum;
      for (k = 0; k < n_bytes; k++) send_rx_byte(octets[k]);
   endtask

   // Holds the sender off until every predicted frame has arrived, then
   // lets the output register settle.
   task automatic wait_for_frames_out();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_request_slots(input logic [SLOTS_W-1:0] slots);
      wait_for_frames_out();
      csr_valid         <= 1'b1;
      csr_request_slots <= slots;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // All-zero frame, a slide past a noise byte into an all-ones adc frame,
   // and a clock reply with the highest id under the reset slot count.
   task automatic test_directed_frames();
      gaps_on    = 1'b0;
      stall_mode = STALL_NONE;
      send_frame(8'h00, 8'h00, 32'h0000_0000, 16'h0000, 1'b0, FRAME_BYTES);
      send_rx_byte(8'hFF);
      send_frame(CMD_ADC, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, FRAME_BYTES);
      send_frame(CMD_CLOCK, 8'hFF, 32'h1234_5678, 16'hA55A, 1'b0, FRAME_BYTES);
   endtask

   // Slot count of zero makes every id bad, one admits only id zero, and a
   // count beyond 256 admits every id.
   task automatic test_slot_limits();
      write_request_slots('0);
      send_frame(CMD_CLOCK, 8'h00, $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
      write_request_slots(9'd1);
      send_frame(CMD_CLOCK, 8'h00, $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
      send_frame(CMD_CLOCK, 8'h01, $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
      write_request_slots(9'h1FF);
      send_frame(CMD_CLOCK, 8'hFF, $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
      write_request_slots(SLOTS_RESET);
   endtask

   // Mostly good frames with random content; the rest are corrupted
   // checksums, cut-off frames and loose noise bytes.
   task automatic test_random_traffic(input int n_bytes, input int slots,
                                      input stall_mode_type mode, input bit gaps,
                                      input bit pause_midway);
      int         start;
      int         pick;
      int         k;
      bit         paused;
      logic [7:0] cmd;
      logic [7:0] value;
      write_request_slots(SLOTS_W'(slots));
      stall_mode = mode;
      gaps_on    = gaps;
      start      = bytes_sent;
      paused     = 1'b0;
      while (bytes_sent - start < n_bytes) begin
         if (pause_midway && !paused && bytes_sent - start >= n_bytes / 2) begin
            wait_for_frames_out();
            paused = 1'b1;
         end
         case ($urandom_range(0, 2))
            0:       cmd = CMD_ADC;
            1:       cmd = CMD_CLOCK;
            default: cmd = 8'($urandom_range(0, 255));
         endcase
         // Ids close to the slot count probe the bad-id boundary.
         if ($urandom_range(0, 3) == 0) value = 8'(slots - $urandom_range(0, 1));
         else value = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(cmd, value, $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
         end else if (pick < 80) begin
            send_frame(cmd, value, $urandom, 16'($urandom), 1'b1, FRAME_BYTES);
         end else if (pick < 90) begin
            send_frame(cmd, value, $urandom, 16'($urandom), 1'b0, $urandom_range(1, 8));
         end else begin
            for (k = $urandom_range(1, 5); k > 0; k--) send_rx_byte(8'($urandom));
         end
      end
   endtask

   // Back-to-back good frames into a heavily stalled receiver fill the
   // queue and push back on the sender.
   task automatic test_backpressure();
      int k;
      write_request_slots(9'd128);
      stall_mode = STALL_HEAVY;
      gaps_on    = 1'b0;
      for (k = 0; k < 16; k++)
         send_frame(($urandom_range(0, 1) == 0) ? CMD_ADC : CMD_CLOCK,
                    8'($urandom), $urandom, 16'($urandom), 1'b0, FRAME_BYTES);
   endtask

   // Test sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_slot_limits();
      test_random_traffic(300, SLOTS_RESET, STALL_LIGHT, 1'b1, 1'b0);
      test_random_traffic(300, $urandom_range(1, 256), STALL_HEAVY, 1'b1, 1'b1);
      test_random_traffic(250, 1, STALL_NONE, 1'b0, 1'b0);
      test_backpressure();
      test_random_traffic(150, $urandom_range(2, 255), STALL_LIGHT, 1'b1, 1'b0);
      wait_for_frames_out();
      repeat (8) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $display("%0t: %0d expected frames never arrived", $time, pending_frames.size());
         errors++;
      end
      $display("Sent %0d bytes and checked %0d frames: %0d adc, %0d clock, %0d bad id, %0d unknown.",
               bytes_sent, frames_checked, kind_seen[KIND_ADC], kind_seen[KIND_CLOCK],
               kind_seen[KIND_BAD_ID], kind_seen[KIND_UNKNOWN]);
      $display("Slot counts 0, 1, 128, 256, 511 and random ones were used under varied pacing.");
      if (errors == 0) begin
         $display("[checksummed_frame_deframer_unit] OK");
      end else begin
         $display("[checksummed_frame_deframer_unit] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("%0t: run timed out", $time);
      $display("[checksummed_frame_deframer_unit] ERROR");
      $finish;
   end

endmodule
